// File: src/base64_stream_decoder_top_defines.svh
// Assertion macros used by the base64 stream decoder checker.
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define B64D_ASSERT_IMPL(label, clk, rstn, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define B64D_ASSERT_NEXT(label, clk, rstn, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (lhs) |=> (rhs)) \
    else $error(msg);

// Same-cycle implication that is also checked during reset.
`define B64D_ASSERT_ALWAYS(label, clk, lhs, rhs, msg) \
  label: assert property (@(posedge clk) (lhs) |-> (rhs)) \
    else $error(msg);

`endif

// File: src/b64d_pkg.sv
// Types, constants and the character classifier of the base64 stream decoder.
package b64d_pkg;

  localparam int unsigned FifoDepth = 4;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharPad    = 8'h3D;

  localparam logic [5:0] SextetPlus  = 6'd62;
  localparam logic [5:0] SextetSlash = 6'd63;
  localparam logic [7:0] LowerBias   = 8'd26;
  localparam logic [7:0] DigitBias   = 8'd52;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } sextet_t;

  // Up to three decoded bytes of one input group, already packed in order.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] count;
    logic       done;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  function automatic sextet_t char_to_sextet(logic [7:0] c);
    sextet_t r;
    r.ok  = 1'b1;
    r.val = '0;
    case (c) inside
      [CharUpperA:CharUpperZ]: r.val = 6'(c - CharUpperA);
      [CharLowerA:CharLowerZ]: r.val = 6'(c - CharLowerA + LowerBias);
      [CharDigit0:CharDigit9]: r.val = 6'(c - CharDigit0 + DigitBias);
      CharPlus:                r.val = SextetPlus;
      CharSlash, CharPad:      r.val = SextetSlash;
      default:                 r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// File: src/b64d_front.sv
// Front end: classifies characters, assembles groups and builds byte records.
module b64d_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      char_code_i,
  input  logic            end_of_text_i,
  output logic            push_o,
  output b64d_pkg::rec_t  rec_o
);

  logic [1:0] gc_q, gc_d;
  logic [5:0] held_q [3];
  logic [5:0] held_d [3];
  logic       pad_q, pad_d;

  b64d_pkg::sextet_t sx;
  logic       is_pad, complete, store, flush, emit, skip2, skip3;
  logic [1:0] gc_st;
  logic [5:0] v3;
  logic [7:0] b0, b1, b2;

  always_comb begin
    sx       = b64d_pkg::char_to_sextet(char_code_i);
    is_pad   = (char_code_i == b64d_pkg::CharPad);
    complete = sx.ok && (gc_q == 2'd3);
    store    = sx.ok && (gc_q != 2'd3);

    held_d = held_q;
    pad_d  = pad_q;
    if (store) begin
      case (gc_q)
        2'd0: held_d[0] = sx.val;
        2'd1: held_d[1] = sx.val;
        2'd2: begin
          held_d[2] = sx.val;
          pad_d     = is_pad;
        end
        default: ;
      endcase
    end
    gc_st = store ? gc_q + 2'd1 : gc_q;

    // Flush completes a partial group with zero sextets.
    flush = end_of_text_i && !complete && (gc_st != 2'd0);
    emit  = complete || flush;
    v3    = complete ? sx.val : 6'd0;
    skip2 = pad_d;
    skip3 = complete && is_pad;

    b0 = {held_d[0], held_d[1][5:4]};
    b1 = {held_d[1][3:0], held_d[2][5:2]};
    b2 = {held_d[2][1:0], v3};

    rec_o.byte0 = b0;
    rec_o.byte1 = skip2 ? b2 : b1;
    rec_o.byte2 = b2;
    rec_o.count = 2'd1 + {1'b0, !skip2} + {1'b0, !skip3};
    rec_o.done  = end_of_text_i;
    push_o      = accept_i && emit;

    gc_d = gc_st;
    if (end_of_text_i || complete) begin
      gc_d      = 2'd0;
      held_d[0] = '0;
      held_d[1] = '0;
      held_d[2] = '0;
      pad_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q      <= 2'd0;
      held_q[0] <= '0;
      held_q[1] <= '0;
      held_q[2] <= '0;
      pad_q     <= 1'b0;
    end else if (accept_i) begin
      gc_q   <= gc_d;
      held_q <= held_d;
      pad_q  <= pad_d;
    end
  end

endmodule

// File: src/b64d_fifo.sv
// Short record queue between the front and back ends.
module b64d_fifo #(
  parameter int unsigned DEPTH = b64d_pkg::FifoDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64d_pkg::rec_t  wdata_i,
  input  logic            pop_i,
  output b64d_pkg::rec_t  rdata_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  b64d_pkg::rec_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: src/b64d_back.sv
// Back end: serializes queued records into one output byte per transfer.
module b64d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  b64d_pkg::rec_t  rec_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      data_byte_o,
  output logic            run_last_o,
  output logic            stream_done_o
);

  b64d_pkg::rec_t cur_q;
  logic           cur_valid_q, cur_valid_d;
  logic [1:0]     idx_q, idx_d;
  logic           fire, last_byte;

  assign fire      = cur_valid_q && !out_stall_i;
  assign last_byte = (idx_q == cur_q.count - 2'd1);
  assign pop_o     = !empty_i && (!cur_valid_q || (fire && last_byte));

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = 2'd0;
    end else if (fire) begin
      if (last_byte) begin
        cur_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= rec_i;
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    data_byte_o = cur_q.byte0;
      2'd1:    data_byte_o = cur_q.byte1;
      default: data_byte_o = cur_q.byte2;
    endcase
  end

  assign out_valid_o   = cur_valid_q;
  assign run_last_o    = last_byte;
  assign stream_done_o = last_byte && cur_q.done;

endmodule

// File: src/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder.
// Takes one character per cycle while the record queue has room.
// Emits one decoded byte per cycle while out_stall_i is low; the first byte of an item
// passes through the queue write and the serializer load before it can transfer.
// Input stalls while all FIFO_DEPTH queue entries hold undelivered records.
// Reset (rst_ni low, asynchronous) clears the open group, the queue and
// the output valid.
module base64_stream_decoder_top #(
  parameter int unsigned FIFO_DEPTH = b64d_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] data_byte_o,
  output logic       run_last_o,
  output logic       stream_done_o
);

  b64d_pkg::rec_t push_rec, pop_rec;
  logic push, pop, empty, full, accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  b64d_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  b64d_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .pop_i   (pop),
    .rdata_o (pop_rec),
    .empty_o (empty),
    .full_o  (full)
  );

  b64d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rec_i         (pop_rec),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .run_last_o    (run_last_o),
    .stream_done_o (stream_done_o)
  );

endmodule

// File: src/b64d_checker.sv
// Port-level assertions for the base64 stream decoder, bound to the top level.
`include "base64_stream_decoder_top_defines.svh"

module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] char_code_i,
  input logic       end_of_text_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] data_byte_o,
  input logic       run_last_o,
  input logic       stream_done_o
);

  `B64D_ASSERT_ALWAYS(a_reset_no_valid, clk_i, !rst_ni, !out_valid_o, "valid during reset")
  `B64D_ASSERT_IMPL(a_done_is_run_last, clk_i, rst_ni, out_valid_o && stream_done_o, run_last_o, "stream end without run end")
  `B64D_ASSERT_NEXT(a_valid_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "stalled output dropped")
  `B64D_ASSERT_NEXT(a_payload_held, clk_i, rst_ni, out_valid_o && out_stall_i, $stable({data_byte_o, run_last_o, stream_done_o}), "stalled output changed")
  `B64D_ASSERT_NEXT(a_in_held, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable({char_code_i, end_of_text_i}), "stalled input changed")

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (.*);
